// ===== hdl/radix_digit_converter_unit_defines.svh =====
`ifndef RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdc check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdc check failed");

`endif

// ===== hdl/rdc_pkg.sv =====
package rdc_pkg;

  localparam int RADIX_W = 9;
  localparam int CHAR_W  = 7;
  localparam int DIV_W   = 7;
  localparam int REM_W   = 6;
  localparam int PC_W    = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd64;
  localparam logic [RADIX_W-1:0] RADIX_BYTES = 9'd256;
  localparam logic [DIV_W-1:0]   DEC_BASE    = 7'd10;
  localparam logic [CHAR_W-1:0]  CHAR_DOT    = 7'h2E;
  localparam logic [CHAR_W-1:0]  CHAR_NUL    = 7'h00;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_WHOLE,
    OP_LOAD_BYTE,
    OP_DIV,
    OP_PUSH_DIGIT,
    OP_PUSH_DOT,
    OP_READ,
    OP_OUT,
    OP_OUT_ERR
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_BAD,
    C_B256,
    C_DIV_MORE,
    C_QNZ,
    C_VZ,
    C_CNT_NZ
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_CHK_B = 4'd1;
  localparam pc_t PC_CHK_W = 4'd2;
  localparam pc_t PC_WHOLE = 4'd3;
  localparam pc_t PC_BYTE  = 4'd4;
  localparam pc_t PC_DIV   = 4'd5;
  localparam pc_t PC_PUSH  = 4'd6;
  localparam pc_t PC_MORE  = 4'd7;
  localparam pc_t PC_DOT   = 4'd8;
  localparam pc_t PC_READ  = 4'd9;
  localparam pc_t PC_OUT   = 4'd10;
  localparam pc_t PC_BACK  = 4'd11;
  localparam pc_t PC_ERR   = 4'd12;

  // control store: no jump taken falls through to pc + 1
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:  c = '{op: OP_ACCEPT,     cond: C_NEVER,    target: PC_IDLE};
      PC_CHK_B: c = '{op: OP_NOP,        cond: C_BAD,      target: PC_ERR};
      PC_CHK_W: c = '{op: OP_NOP,        cond: C_B256,     target: PC_BYTE};
      PC_WHOLE: c = '{op: OP_LOAD_WHOLE, cond: C_ALWAYS,   target: PC_DIV};
      PC_BYTE:  c = '{op: OP_LOAD_BYTE,  cond: C_NEVER,    target: PC_IDLE};
      PC_DIV:   c = '{op: OP_DIV,        cond: C_DIV_MORE, target: PC_DIV};
      PC_PUSH:  c = '{op: OP_PUSH_DIGIT, cond: C_QNZ,      target: PC_DIV};
      PC_MORE:  c = '{op: OP_NOP,        cond: C_VZ,       target: PC_READ};
      PC_DOT:   c = '{op: OP_PUSH_DOT,   cond: C_ALWAYS,   target: PC_BYTE};
      PC_READ:  c = '{op: OP_READ,       cond: C_NEVER,    target: PC_IDLE};
      PC_OUT:   c = '{op: OP_OUT,        cond: C_CNT_NZ,   target: PC_READ};
      PC_BACK:  c = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
      PC_ERR:   c = '{op: OP_OUT_ERR,    cond: C_ALWAYS,   target: PC_IDLE};
      default:  c = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return c;
  endfunction

  // digit alphabet 0-9, A-Z, a-z, '+', '/'
  function automatic logic [CHAR_W-1:0] digit_char(logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] dz;
    logic [CHAR_W-1:0] ch;
    dz = {1'b0, d};
    if (d < 6'd10) begin
      ch = 7'h30 + dz;
    end else if (d < 6'd36) begin
      ch = 7'h41 + dz - 7'd10;
    end else if (d < 6'd62) begin
      ch = 7'h61 + dz - 7'd36;
    end else if (d == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== hdl/rdc_ram.sv =====
module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/radix_digit_converter_unit.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: char_code, tlast: last, tuser: bad_radix
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i: radix
//
// digits come from a restoring divider that retires 8 quotient bits a cycle,
// so one digit takes a divide step per byte of the value and then a push onto the stack
// reset clears the sequencer, the stack count and the output valid bit; radix resets to 10
// a stalled output holds the sequencer at its output step; input is taken only at idle

`include "radix_digit_converter_unit_defines.svh"

module radix_digit_converter_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [VALUE_BITS-1:0] value
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [6:0] char_code
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser,  // [0] bad_radix
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0]          cfg_data_i
);

  localparam int CHUNKS = (VALUE_BITS + 7) / 8;
  localparam int QW     = CHUNKS * 8;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam logic [CW-1:0]    CHUNK_LAST = CW'(CHUNKS - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(VALUE_BITS);

  rdc_pkg::pc_t  pc_q, pc_d;
  rdc_pkg::ctrl_t ctrl;

  logic [rdc_pkg::RADIX_W-1:0] radix_q;
  logic [VALUE_BITS-1:0]       v_q, v_d;
  logic [QW-1:0]               q_q, q_d;
  logic [rdc_pkg::REM_W-1:0]   rem_q, rem_d;
  logic [rdc_pkg::DIV_W-1:0]   div_q, div_d;
  logic [CW-1:0]               chunk_q, chunk_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CNT_W-1:0]            cnt_m1;

  logic                        out_valid_q, out_valid_d;
  logic [rdc_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
  logic                        out_last_q, out_last_d;
  logic                        out_bad_q, out_bad_d;
  logic                        out_free;

  logic                        in_acc;
  logic                        bad_radix;
  logic                        is_b256;
  logic                        stall;
  logic                        jump;

  logic [QW-1:0]               qs;
  logic [rdc_pkg::DIV_W-1:0]   rs;
  logic [rdc_pkg::REM_W-1:0]   rem_step;

  logic                        ram_we;
  logic [rdc_pkg::CHAR_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [rdc_pkg::CHAR_W-1:0]  ram_rdata;

  assign ctrl      = rdc_pkg::ucode(pc_q);
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (ctrl.op == rdc_pkg::OP_ACCEPT);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cnt_m1    = cnt_q - CNT_W'(1);

  assign is_b256   = (radix_q == rdc_pkg::RADIX_BYTES);
  assign bad_radix = !(((radix_q >= rdc_pkg::RADIX_MIN) && (radix_q <= rdc_pkg::RADIX_MAX))
                       || is_b256);

  // eight restoring steps on a narrow remainder
  always_comb begin
    qs = q_q;
    rs = '0;
    rem_step = rem_q;
    for (int i = 0; i < 8; i++) begin
      rs = {rem_step, qs[QW-1]};
      if (rs >= div_q) begin
        rs = rs - div_q;
        qs = {qs[QW-2:0], 1'b1};
      end else begin
        qs = {qs[QW-2:0], 1'b0};
      end
      rem_step = rs[rdc_pkg::REM_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.cond)
      rdc_pkg::C_NEVER:    jump = 1'b0;
      rdc_pkg::C_ALWAYS:   jump = 1'b1;
      rdc_pkg::C_BAD:      jump = bad_radix;
      rdc_pkg::C_B256:     jump = is_b256;
      rdc_pkg::C_DIV_MORE: jump = (chunk_q != '0);
      rdc_pkg::C_QNZ:      jump = (q_q != '0);
      rdc_pkg::C_VZ:       jump = (v_q == '0);
      rdc_pkg::C_CNT_NZ:   jump = (cnt_q != '0);
      default:             jump = 1'b0;
    endcase
  end

  always_comb begin
    stall = 1'b0;
    v_d = v_q;
    q_d = q_q;
    rem_d = rem_q;
    div_d = div_q;
    chunk_d = chunk_q;
    cnt_d = cnt_q;
    ram_we = 1'b0;
    ram_wdata = rdc_pkg::digit_char(rem_q);
    ram_re = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    out_bad_d = out_bad_q;

    unique case (ctrl.op)
      rdc_pkg::OP_NOP: begin
      end
      rdc_pkg::OP_ACCEPT: begin
        stall = !s_axis_tvalid;
        if (in_acc) begin
          v_d = s_axis_tdata[VALUE_BITS-1:0];
          cnt_d = '0;
        end
      end
      rdc_pkg::OP_LOAD_WHOLE: begin
        q_d = QW'(v_q);
        v_d = '0;
        div_d = radix_q[rdc_pkg::DIV_W-1:0];
        rem_d = '0;
        chunk_d = CHUNK_LAST;
      end
      rdc_pkg::OP_LOAD_BYTE: begin
        q_d = QW'(v_q[7:0]);
        v_d = v_q >> 8;
        div_d = rdc_pkg::DEC_BASE;
        rem_d = '0;
        chunk_d = CHUNK_LAST;
      end
      rdc_pkg::OP_DIV: begin
        q_d = qs;
        rem_d = rem_step;
        chunk_d = chunk_q - CW'(1);
      end
      rdc_pkg::OP_PUSH_DIGIT: begin
        ram_we = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        rem_d = '0;
        chunk_d = CHUNK_LAST;
      end
      rdc_pkg::OP_PUSH_DOT: begin
        ram_we = 1'b1;
        ram_wdata = rdc_pkg::CHAR_DOT;
        cnt_d = cnt_q + CNT_W'(1);
      end
      rdc_pkg::OP_READ: begin
        ram_re = 1'b1;
        cnt_d = cnt_m1;
      end
      rdc_pkg::OP_OUT: begin
        stall = !out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d = ram_rdata;
          out_last_d = (cnt_q == '0);
          out_bad_d = 1'b0;
        end
      end
      rdc_pkg::OP_OUT_ERR: begin
        stall = !out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d = rdc_pkg::CHAR_NUL;
          out_last_d = 1'b1;
          out_bad_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + rdc_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= rdc_pkg::PC_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      radix_q <= rdc_pkg::RADIX_RESET;
    end else begin
      pc_q <= pc_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    q_q <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
    chunk_q <= chunk_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q <= out_bad_d;
  end

  rdc_ram #(
    .WIDTH(rdc_pkg::CHAR_W),
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_m1[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

  `RDC_ASSERT_NOW(a_stack_bound, 1'b1, cnt_q <= DEPTH_CNT)
  `RDC_ASSERT_NOW(a_accept_empty, in_acc, cnt_q == '0)
  `RDC_ASSERT_NOW(a_err_shape, out_valid_q && out_bad_q, out_last_q && (out_char_q == '0))
  `RDC_ASSERT_NEXT(a_read_then_out, ctrl.op == rdc_pkg::OP_READ, pc_q == rdc_pkg::PC_OUT)

endmodule

// ===== bench/tb_radix_digit_converter_unit.sv =====
`timescale 1ns / 100ps

module tb_radix_digit_converter_unit;

  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] char_code;
    logic                       last;
    logic                       bad_radix;
  } char_t;

  class char_scoreboard;
    logic [rdc_pkg::RADIX_W-1:0] radix;
    char_t                       awaited_chars[$];
    string                       alphabet;
    int                          errors;
    int                          values_seen;
    int                          chars_seen;

    function new();
      radix       = rdc_pkg::RADIX_RESET;
      alphabet    = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";
      errors      = 0;
      values_seen = 0;
      chars_seen  = 0;
    endfunction

    function int outstanding();
      return awaited_chars.size();
    endfunction

    // digits of v in base b, least significant first
    function void stack_digits(logic [31:0] v, logic [rdc_pkg::RADIX_W-1:0] b,
                               ref logic [rdc_pkg::CHAR_W-1:0] rev[$]);
      logic [31:0] w;
      w = v;
      do begin
        rev.push_back(rdc_pkg::CHAR_W'(alphabet[int'(w % b)]));
        w = w / b;
      end while (w != 0);
    endfunction

    function void note_value(logic [31:0] v);
      logic [rdc_pkg::CHAR_W-1:0] rev[$];
      logic [31:0]                w;
      bit                         first;
      char_t                      c;
      values_seen++;
      if (!((radix >= rdc_pkg::RADIX_MIN && radix <= rdc_pkg::RADIX_MAX)
            || radix == rdc_pkg::RADIX_BYTES)) begin
        c = '{char_code: rdc_pkg::CHAR_NUL, last: 1'b1, bad_radix: 1'b1};
        awaited_chars.push_back(c);
        return;
      end
      if (radix == rdc_pkg::RADIX_BYTES) begin
        // bytes from the bottom up, dropping leading zero bytes
        w = v;
        first = 1'b1;
        do begin
          if (!first) rev.push_back(rdc_pkg::CHAR_DOT);
          stack_digits(w & 32'hFF, rdc_pkg::RADIX_W'(rdc_pkg::DEC_BASE), rev);
          w = w >> 8;
          first = 1'b0;
        end while (w != 0);
      end else begin
        stack_digits(v, radix, rev);
      end
      for (int k = rev.size() - 1; k >= 0; k--) begin
        c = '{char_code: rev[k], last: (k == 0), bad_radix: 1'b0};
        awaited_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] data, logic last, logic bad);
      char_t e;
      chars_seen++;
      if (awaited_chars.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: char_code %h last %b bad_radix %b",
                 $time, data[rdc_pkg::CHAR_W-1:0], last, bad);
        return;
      end
      e = awaited_chars.pop_front();
      if (data[rdc_pkg::CHAR_W-1:0] !== e.char_code) begin
        errors++;
        $display("%0t char_code mismatch: expected %h actual %h",
                 $time, e.char_code, data[rdc_pkg::CHAR_W-1:0]);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t last mismatch: expected %b actual %b", $time, e.last, last);
      end
      if (bad !== e.bad_radix) begin
        errors++;
        $display("%0t bad_radix mismatch: expected %b actual %b", $time, e.bad_radix, bad);
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        m_axis_tuser;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [rdc_pkg::RADIX_W-1:0] cfg_data_i;

  char_scoreboard sb = new();
  bit             calm;
  bit             src_push;
  bit             hold_req;
  int             radix_writes;

  radix_digit_converter_unit #(.VALUE_BITS(32)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    logic [3:0]  keep;
    v = $urandom;
    keep = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 300);
      2: v = v & {{8{keep[3]}}, {8{keep[2]}}, {8{keep[1]}}, {8{keep[0]}}};
      default: v = v >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = (calm || src_push) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_value(v);
  endtask

  // radix changes only once the block has emptied
  task automatic set_radix(input logic [rdc_pkg::RADIX_W-1:0] r);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.radix = r;
    radix_writes++;
  endtask

  task automatic random_phase(input logic [rdc_pkg::RADIX_W-1:0] r, input int n);
    set_radix(r);
    repeat (n) send_value(random_value());
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // output side, long hold-off counted here
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int gap;
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid) sb.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  initial begin
    logic [rdc_pkg::RADIX_W-1:0] r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    calm          = 1'b0;
    src_push      = 1'b0;
    hold_req      = 1'b0;
    radix_writes  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // base 10 straight out of reset
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd1_000_000_000);
    set_radix(9'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    // base 3 is not a power of two
    set_radix(9'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'd8);
    set_radix(9'd16);
    send_value(32'hDEAD_BEEF);
    set_radix(rdc_pkg::RADIX_MAX);
    send_value(32'd63);
    send_value(32'd64);
    send_value(32'hFFFF_FFFF);
    // dotted bytes, interior zero bytes print as 0
    set_radix(rdc_pkg::RADIX_BYTES);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0100_0001);
    send_value(32'h0001_0000);
    send_value(32'h7F00_0001);
    // invalid bases
    set_radix(9'd0);
    send_value(32'h1234_5678);
    set_radix(9'd1);
    send_value(32'd5);
    set_radix(9'd65);
    send_value(32'hFFFF_FFFF);
    set_radix(9'd255);
    send_value(32'd7);
    set_radix(9'd511);
    send_value(32'd0);
    set_radix(9'd257);
    send_value(32'd3);

    random_phase(9'd10, 8);
    set_radix(9'd2);
    src_push = 1'b1;
    hold_req = 1'b1;
    repeat (10) send_value(random_value());
    src_push = 1'b0;
    random_phase(9'd16, 6);
    calm = 1'b1;
    random_phase(rdc_pkg::RADIX_MAX, 8);
    calm = 1'b0;
    random_phase(rdc_pkg::RADIX_BYTES, 8);
    random_phase(9'($urandom_range(2, 64)), 6);
    random_phase(9'($urandom_range(2, 64)), 6);
    random_phase(rdc_pkg::RADIX_BYTES, 6);
    do r = 9'($urandom_range(0, 511));
    while ((r >= rdc_pkg::RADIX_MIN && r <= rdc_pkg::RADIX_MAX) || r == rdc_pkg::RADIX_BYTES);
    random_phase(r, 3);
    random_phase(9'($urandom_range(2, 64)), 6);
    random_phase(9'd10, 6);

    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.outstanding() != 0)
      $display("%0t %0d characters never arrived", $time, sb.outstanding());
    $display("summary: %0d values converted into %0d characters over %0d radix writes",
             sb.values_seen, sb.chars_seen, radix_writes);
    $display("summary: bases 2 to 64, dotted bytes, invalid bases and a long output hold-off");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
